// ===== hw/rtl/lcrd_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the record deframer.
`default_nettype none

package lcrd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay;
    logic        has_stat;
    logic [1:0]  status;
    logic [24:0] consumed;
  } entry_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcrd_front.sv =====
// Front end: parses length, payload and CRC bytes and issues queue entries.
`default_nettype none

module lcrd_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_end_of_buffer,
  input  wire logic                 cfg_valid,
  input  wire logic [23:0]          cfg_max_payload_bytes,
  output logic                      q_push,
  output lcrd_pkg::entry_t          q_data
);
  import lcrd_pkg::*;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_PAY  = 4'b0010,
    PH_CRC  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [24:0] cnt_r, cnt_nxt;
  logic [23:0] len_r, len_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] rx_r, rx_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] max_r;
  logic        accept;
  entry_t      ent;

  assign accept = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    rx_nxt    = rx_r;
    pos_nxt   = pos_r;
    ent       = '0;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          crc_nxt = crc32_byte(crc_r, in_data_byte);
          cnt_nxt = 25'(cnt_r + 25'd1);
          case (cnt_r[1:0])
            2'd0: len_nxt[7:0]   = in_data_byte;
            2'd1: len_nxt[15:8]  = in_data_byte;
            2'd2: len_nxt[23:16] = in_data_byte;
            default: begin
              if ((in_data_byte != 8'd0) || (len_r > max_r)) begin
                ent.has_stat = 1'b1;
                ent.status   = ST_CORRUPT;
                phase_nxt    = PH_DONE;
              end else if (len_r == 24'd0) begin
                phase_nxt = PH_CRC;
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          endcase
        end
        PH_PAY: begin
          ent.has_pay = 1'b1;
          ent.pay     = in_data_byte;
          crc_nxt     = crc32_byte(crc_r, in_data_byte);
          cnt_nxt     = 25'(cnt_r + 25'd1);
          if (25'(cnt_r + 25'd1) == 25'(25'd4 + {1'b0, len_r})) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          cnt_nxt = 25'(cnt_r + 25'd1);
          pos_nxt = 2'(pos_r + 2'd1);
          case (pos_r)
            2'd0: rx_nxt[7:0]   = in_data_byte;
            2'd1: rx_nxt[15:8]  = in_data_byte;
            2'd2: rx_nxt[23:16] = in_data_byte;
            default: begin
              ent.has_stat = 1'b1;
              if (~crc_r == {in_data_byte, rx_r}) begin
                ent.status   = ST_OK;
                ent.consumed = 25'(cnt_r + 25'd1);
              end else begin
                ent.status = ST_CORRUPT;
              end
              phase_nxt = PH_DONE;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
      if (in_end_of_buffer) begin
        if (phase_nxt != PH_DONE) begin
          ent.has_stat = 1'b1;
          ent.status   = ST_TRUNC;
          ent.consumed = '0;
        end
        phase_nxt = PH_LEN;
        cnt_nxt   = '0;
        len_nxt   = '0;
        crc_nxt   = CRC_INIT;
        rx_nxt    = '0;
        pos_nxt   = '0;
      end
    end
  end

  assign q_push = accept && (ent.has_pay || ent.has_stat);
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cnt_r   <= '0;
      len_r   <= '0;
      crc_r   <= CRC_INIT;
      rx_r    <= '0;
      pos_r   <= '0;
      max_r   <= 24'd65536;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      rx_r    <= rx_nxt;
      pos_r   <= pos_nxt;
      if (cfg_valid) begin
        max_r <= cfg_max_payload_bytes;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcrd_queue.sv =====
// Small FIFO of result entries between the front and back ends.
`default_nettype none

module lcrd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcrd_pkg::entry_t push_data,
  input  wire logic             pop,
  output lcrd_pkg::entry_t      head,
  output logic                  not_empty,
  output logic                  full
);
  import lcrd_pkg::*;

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (QAW+1)'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = (QAW+1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcrd_back.sv =====
// Back end: splits queue entries into payload and status results in an output register.
`default_nettype none

module lcrd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lcrd_pkg::entry_t head,
  input  wire logic             not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_result_kind,
  output logic [7:0]            out_payload_byte,
  output logic [1:0]            out_decode_status,
  output logic [24:0]           out_frame_bytes,
  output logic                  out_last_result
);
  import lcrd_pkg::*;

  logic        vld_r, vld_nxt;
  logic        pay_done_r, pay_done_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  pay_r, pay_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [24:0] cons_r, cons_nxt;
  logic        load;

  assign load = not_empty && (!vld_r || out_ready);

  always_comb begin
    vld_nxt      = (vld_r && !out_ready) || load;
    pay_done_nxt = pay_done_r;
    kind_nxt     = kind_r;
    pay_nxt      = pay_r;
    stat_nxt     = stat_r;
    cons_nxt     = cons_r;
    pop          = 1'b0;
    if (load) begin
      if (head.has_pay && !pay_done_r) begin
        kind_nxt = 1'b0;
        pay_nxt  = head.pay;
        stat_nxt = ST_OK;
        cons_nxt = '0;
        if (head.has_stat) begin
          pay_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        kind_nxt     = 1'b1;
        pay_nxt      = '0;
        stat_nxt     = head.status;
        cons_nxt     = head.consumed;
        pay_done_nxt = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      pay_done_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      pay_done_r <= pay_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pay_r  <= pay_nxt;
    stat_r <= stat_nxt;
    cons_r <= cons_nxt;
  end

  assign out_valid         = vld_r;
  assign out_result_kind   = kind_r;
  assign out_payload_byte  = pay_r;
  assign out_decode_status = stat_r;
  assign out_frame_bytes   = cons_r;
  assign out_last_result   = kind_r;

endmodule

`default_nettype wire

// ===== hw/rtl/length_crc32_record_deframer.sv =====
// Top level of the length-prefixed record deframer with CRC-32 check.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid/in_ready, in_data_byte, in_end_of_buffer  | sink
//  out     | out_valid/out_ready, kind, byte, status, consumed  | source
//  cfg     | cfg_valid/cfg_ready, cfg_max_payload_bytes         | sink
//
// One byte per cycle enters while in_ready is high; the front end updates
// CRC-32 a byte per cycle. Results leave at one per cycle via the output
// register while out_ready is high; a byte ending payload and buffer
// yields two results. Synchronous active-low reset; max payload resets to
// 65536. A 4-entry queue absorbs output stalls; in_ready drops when full.
`default_nettype none

module length_crc32_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_decode_status,
  output logic [24:0]      out_frame_bytes,
  output logic             out_last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_max_payload_bytes
);
  import lcrd_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_not_empty;
  logic   q_full;
  entry_t q_in;
  entry_t q_head;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  lcrd_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_end_of_buffer      (in_end_of_buffer),
    .cfg_valid             (cfg_valid),
    .cfg_max_payload_bytes (cfg_max_payload_bytes),
    .q_push                (q_push),
    .q_data                (q_in)
  );

  lcrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lcrd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .not_empty         (q_not_empty),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_decode_status (out_decode_status),
    .out_frame_bytes   (out_frame_bytes),
    .out_last_result   (out_last_result)
  );

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_ok_consumed_min : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind && (out_decode_status == ST_OK))
      |-> (out_frame_bytes >= 25'd8))
    else $error("ok status with fewer than eight bytes consumed");

  a_bad_consumed_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind && (out_decode_status != ST_OK))
      |-> (out_frame_bytes == 25'd0))
    else $error("failed status with nonzero byte count");

  a_payload_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_kind)
      |-> (!out_last_result && (out_decode_status == ST_OK)))
    else $error("payload transfer carries status fields");

endmodule

`default_nettype wire

// ===== dv/record_deframer_checker.sv =====
// Monitor, byte-level predictor and result comparator for the record deframer.
module record_deframer_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_result_kind,
  input  wire logic [7:0]  out_payload_byte,
  input  wire logic [1:0]  out_decode_status,
  input  wire logic [24:0] out_frame_bytes,
  input  wire logic        out_last_result,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [23:0] cfg_max_payload_bytes,
  output int               fail_count,
  output int               pending,
  output int               payload_count,
  output int               ok_count,
  output int               truncated_count,
  output int               corrupt_count
);
  import lcrd_pkg::*;

  typedef enum logic [1:0] {PH_LENGTH, PH_PAYLOAD, PH_CRC, PH_DONE} frame_phase_t;

  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;
  localparam logic [23:0] MAX_RESET    = 24'd65536;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [24:0] consumed;
    logic        last;
  } deframe_result_t;

  deframe_result_t expected_results[$];

  frame_phase_t phase;
  logic [24:0]  byte_count;
  logic [31:0]  length_field;
  logic [31:0]  crc_reg;
  logic [31:0]  crc_field;
  logic [23:0]  max_len;

  function automatic logic [31:0] crc32_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ ((c[0] ^ b[i]) ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  task automatic start_buffer();
    phase        = PH_LENGTH;
    byte_count   = '0;
    length_field = '0;
    crc_reg      = CRC_INIT;
    crc_field    = '0;
  endtask

  task automatic expect_status(input logic [1:0] st, input logic [24:0] consumed);
    expected_results.push_back('{KIND_STATUS, 8'd0, st, consumed, 1'b1});
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eob);
    logic [24:0] crc_offset;
    case (phase)
      PH_LENGTH: begin
        length_field = length_field | ({24'd0, b} << {byte_count[1:0], 3'b000});
        crc_reg      = crc32_advance(crc_reg, b);
        byte_count   = byte_count + 25'd1;
        if (byte_count == 25'd4) begin
          if (length_field > {8'd0, max_len}) begin
            expect_status(ST_CORRUPT, 25'd0);
            phase = PH_DONE;
          end else begin
            phase = (length_field == 32'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        expected_results.push_back('{KIND_PAYLOAD, b, ST_OK, 25'd0, 1'b0});
        crc_reg    = crc32_advance(crc_reg, b);
        byte_count = byte_count + 25'd1;
        if ({7'd0, byte_count} == length_field + 32'd4) phase = PH_CRC;
      end
      PH_CRC: begin
        crc_offset = byte_count - 25'd4 - length_field[24:0];
        crc_field  = crc_field | ({24'd0, b} << {crc_offset[1:0], 3'b000});
        byte_count = byte_count + 25'd1;
        if (crc_offset[1:0] == 2'd3) begin
          if (~crc_reg == crc_field) expect_status(ST_OK, byte_count);
          else expect_status(ST_CORRUPT, 25'd0);
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (eob) begin
      if (phase != PH_DONE) expect_status(ST_TRUNC, 25'd0);
      start_buffer();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (!rst_n) begin
      max_len = MAX_RESET;
      start_buffer();
      expected_results.delete();
      fail_count      = 0;
      payload_count   = 0;
      ok_count        = 0;
      truncated_count = 0;
      corrupt_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) max_len = cfg_max_payload_bytes;
      if (in_valid && in_ready) predict_byte(in_data_byte, in_end_of_buffer);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result: kind %0d byte 0x%0h status %0d",
                 out_result_kind, out_payload_byte, out_decode_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
          check_field("payload_byte", 32'(want.data), 32'(out_payload_byte));
          check_field("decode_status", 32'(want.status), 32'(out_decode_status));
          check_field("frame_bytes", 32'(want.consumed), 32'(out_frame_bytes));
          check_field("last_result", 32'(want.last), 32'(out_last_result));
        end
        if (out_result_kind == KIND_PAYLOAD) begin
          payload_count++;
        end else begin
          case (out_decode_status)
            ST_OK:    ok_count++;
            ST_TRUNC: truncated_count++;
            default:  corrupt_count++;
          endcase
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/length_crc32_record_deframer_test.sv =====
// Top-level testbench: clock, reset, record stimulus, config phases and verdict.
module length_crc32_record_deframer_test;

  typedef enum int {REC_GOOD, REC_BAD_CRC, REC_OVERSIZED, REC_TRUNCATED, REC_NOISE}
    record_style_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 23;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_decode_status;
  logic [24:0] out_frame_bytes;
  logic        out_last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_max_payload_bytes = 24'd0;

  int fail_count;
  int pending;
  int payload_count;
  int ok_count;
  int truncated_count;
  int corrupt_count;

  int          cycle_count = 0;
  int          idle_pct = IDLE_PCT;
  int          bytes_sent = 0;
  int          records_sent = 0;
  logic [23:0] cur_max = 24'd65536;
  logic [7:0]  record_bytes[$];

  length_crc32_record_deframer dut (.*);

  record_deframer_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ lcrd_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic frame_record(input logic [31:0] len, input bit bad_crc);
    logic [31:0] crc;
    logic [7:0]  b;
    crc = lcrd_pkg::CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      b = len[8*i +: 8];
      record_bytes.push_back(b);
      crc = crc32_update(crc, b);
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom());
      record_bytes.push_back(b);
      crc = crc32_update(crc, b);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int i = 0; i < 4; i++) record_bytes.push_back(crc[8*i +: 8]);
  endtask

  task automatic add_trailing();
    repeat ($urandom_range(1) * $urandom_range(3)) record_bytes.push_back(8'($urandom()));
  endtask

  task automatic build_record(input record_style_t style);
    logic [31:0] len;
    logic [31:0] cap;
    int          cut;
    record_bytes.delete();
    cap = (cur_max < 24'd12) ? {8'd0, cur_max} : 32'd12;
    if ($urandom_range(19) == 0) cap = (cur_max < 24'd150) ? {8'd0, cur_max} : 32'd150;
    len = $urandom_range(cap, 0);
    case (style)
      REC_GOOD: begin
        frame_record(len, 1'b0);
        add_trailing();
      end
      REC_BAD_CRC: begin
        frame_record(len, 1'b1);
        add_trailing();
      end
      REC_OVERSIZED: begin
        len = $urandom_range(1) ? $urandom()
                                : {8'd0, cur_max} + 32'd1 + $urandom_range(300);
        if (len <= {8'd0, cur_max}) len = {8'd0, cur_max} + 32'd1;
        for (int i = 0; i < 4; i++) record_bytes.push_back(len[8*i +: 8]);
        add_trailing();
      end
      REC_TRUNCATED: begin
        frame_record(len, 1'b0);
        cut = $urandom_range(record_bytes.size() - 1, 1);
        while (record_bytes.size() > cut) void'(record_bytes.pop_back());
      end
      default: begin
        repeat ($urandom_range(12, 1)) record_bytes.push_back(8'($urandom()));
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (record_bytes[i]) send_byte(record_bytes[i], i == record_bytes.size() - 1);
    records_sent++;
  endtask

  task automatic run_random(input int n_bytes);
    int target;
    int roll;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 55) build_record(REC_GOOD);
      else if (roll < 65) build_record(REC_BAD_CRC);
      else if (roll < 75) build_record(REC_OVERSIZED);
      else if (roll < 90) build_record(REC_TRUNCATED);
      else build_record(REC_NOISE);
      send_buffer();
    end
  endtask

  task automatic write_max(input logic [23:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid             <= 1'b1;
    cfg_max_payload_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_max = value;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    record_bytes.delete();
    frame_record(32'd0, 1'b0);
    send_buffer();
    record_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    record_bytes = {8'h5A};
    send_buffer();
    record_bytes.delete();
    frame_record(32'd1, 1'b0);
    while (record_bytes.size() > 5) void'(record_bytes.pop_back());
    send_buffer();
    record_bytes.delete();
    frame_record(32'd2, 1'b0);
    record_bytes.push_back(8'h00);
    send_buffer();

    write_max(24'd0);
    run_random(150);
    write_max(24'hFFFFFF);
    idle_pct = 0;
    run_random(200);
    idle_pct = IDLE_PCT;
    write_max(24'($urandom_range(40, 1)));
    run_random(250);
    write_max(24'd65536);
    run_random(320);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d bytes in %0d buffers across five max-payload settings.",
             bytes_sent, records_sent);
    $display("Saw %0d payload bytes and %0d ok, %0d truncated, %0d corrupt statuses.",
             payload_count, ok_count, truncated_count, corrupt_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== length_crc32_record_deframer.f =====
hw/rtl/lcrd_pkg.sv
hw/rtl/lcrd_front.sv
hw/rtl/lcrd_queue.sv
hw/rtl/lcrd_back.sv
hw/rtl/length_crc32_record_deframer.sv
dv/record_deframer_checker.sv
dv/length_crc32_record_deframer_test.sv
